### rtl/tdwf_pkg.sv
// Shared types, constants and helpers for the tile drive wall follow controller.
`timescale 1ns / 1ps

package tdwf_pkg;

  localparam int SENSOR_BITS = 10;
  localparam int COUNT_BITS  = 32;

  // Register field widths
  localparam int SPEED_BITS  = 7;
  localparam int THRESH_BITS = 10;
  localparam int TILE_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int INDEX_BITS  = 3;
  localparam int OUT_SPEED_BITS = 8;

  // Sensor values and thresholds are compared at a common width
  localparam int VAL_BITS   = (SENSOR_BITS > THRESH_BITS) ? SENSOR_BITS : THRESH_BITS;
  localparam int DIFF_BITS  = VAL_BITS + 1;
  localparam int STEER_BITS = VAL_BITS + 10;
  localparam int SPD_BITS   = STEER_BITS + 1;
  // Position compares: position plus a 16-bit offset, no wrap
  localparam int POS_BITS   = ((COUNT_BITS > TILE_BITS) ? COUNT_BITS : TILE_BITS) + 2;

  localparam int GAIN_DIR          = 95;
  localparam int GAIN_DIST         = 38;
  localparam int FRONT_BACK_MARGIN = -60;
  localparam int KIND1_FRONT_TH    = 210;
  localparam int KIND2_FRONT_TH    = 130;
  localparam int KIND2_FRONT_STOP  = 255;
  localparam int KIND4_BACK_TH     = 500;
  localparam int KIND5_BACK_TH     = 250;
  localparam int KIND4_BACK_STOP   = 380;
  localparam int KIND5_BACK_STOP   = 185;

  // Register indexes
  localparam logic [INDEX_BITS-1:0] REG_MAX_SPEED      = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_SIDE_THRESHOLD = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_WALL_TARGET    = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_FRONT_STOP     = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_TILE_COUNTS    = 3'd4;
  localparam logic [INDEX_BITS-1:0] REG_ABORT_COUNTS   = 3'd5;

  // Phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DRIVE = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;
  localparam logic [1:0] PH_SPARE = 2'd3;

  // Stop rule kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_FRONT  = 3'd1;
  localparam logic [2:0] KIND_FRONT2 = 3'd2;
  localparam logic [2:0] KIND_DIST   = 3'd3;
  localparam logic [2:0] KIND_BACK4  = 3'd4;
  localparam logic [2:0] KIND_BACK5  = 3'd5;
  localparam logic [2:0] KIND_DIST6  = 3'd6;
  localparam logic [2:0] KIND_SPARE  = 3'd7;

  // Status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_DRIVING = 2'd1;
  localparam logic [1:0] ST_MIDDLE  = 2'd2;
  localparam logic [1:0] ST_BEFORE  = 2'd3;

  typedef struct packed {
    logic [SPEED_BITS-1:0]  max_speed;
    logic [THRESH_BITS-1:0] side_threshold;
    logic [THRESH_BITS-1:0] wall_target;
    logic [THRESH_BITS-1:0] front_stop;
    logic [TILE_BITS-1:0]   tile_counts;
    logic [TILE_BITS-1:0]   abort_counts;
  } cfg_t;

  typedef struct packed {
    logic signed [COUNT_BITS-1:0] left_count;
    logic signed [COUNT_BITS-1:0] right_count;
    logic [SENSOR_BITS-1:0]       top_front;
    logic [SENSOR_BITS-1:0]       top_back;
    logic [SENSOR_BITS-1:0]       right_front;
    logic [SENSOR_BITS-1:0]       right_back;
    logic [SENSOR_BITS-1:0]       left_front;
    logic [SENSOR_BITS-1:0]       left_back;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                       status;
    logic                             speeds_valid;
    logic signed [OUT_SPEED_BITS-1:0] left_speed;
    logic signed [OUT_SPEED_BITS-1:0] right_speed;
  } out_item_t;

  // Signed divide by 256, truncating toward zero
  function automatic logic signed [STEER_BITS-1:0] div256_trunc(
    input logic signed [STEER_BITS-1:0] v
  );
    logic signed [STEER_BITS-1:0] b;
    b = v + (v[STEER_BITS-1] ? STEER_BITS'(255) : STEER_BITS'(0));
    return b >>> 8;
  endfunction

endpackage

### rtl/tile_drive_wall_follow_controller.sv
// Top level: configuration registers, input register and result register.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_data   (tdwf_pkg::in_item_t)
//  out      output     out_valid / out_ready  out_data  (tdwf_pkg::out_item_t)
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// Each transaction passes through the input register and then lands in the
// result register; one transaction per cycle sustained while out is not stalled.
// The run state is updated as the item moves into the result register.
// Reset (rst, synchronous) restores register defaults and the idle run state.
// A stall on out holds the result register and backs up the input register.
`timescale 1ns / 1ps

module tile_drive_wall_follow_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tdwf_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tdwf_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [tdwf_pkg::INDEX_BITS-1:0]   cfg_index,
  input  logic [tdwf_pkg::CFG_BITS-1:0]     cfg_data
);

  tdwf_pkg::cfg_t      cfg;
  tdwf_pkg::in_item_t  in_q;
  tdwf_pkg::out_item_t res;
  logic                in_valid_q;
  logic                load_out;

  assign load_out = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed      <= tdwf_pkg::SPEED_BITS'(50);
      cfg.side_threshold <= tdwf_pkg::THRESH_BITS'(180);
      cfg.wall_target    <= tdwf_pkg::THRESH_BITS'(300);
      cfg.front_stop     <= tdwf_pkg::THRESH_BITS'(520);
      cfg.tile_counts    <= tdwf_pkg::TILE_BITS'(1230);
      cfg.abort_counts   <= tdwf_pkg::TILE_BITS'(1353);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tdwf_pkg::REG_MAX_SPEED:      cfg.max_speed      <= cfg_data[tdwf_pkg::SPEED_BITS-1:0];
        tdwf_pkg::REG_SIDE_THRESHOLD: cfg.side_threshold <= cfg_data[tdwf_pkg::THRESH_BITS-1:0];
        tdwf_pkg::REG_WALL_TARGET:    cfg.wall_target    <= cfg_data[tdwf_pkg::THRESH_BITS-1:0];
        tdwf_pkg::REG_FRONT_STOP:     cfg.front_stop     <= cfg_data[tdwf_pkg::THRESH_BITS-1:0];
        tdwf_pkg::REG_TILE_COUNTS:    cfg.tile_counts    <= cfg_data[tdwf_pkg::TILE_BITS-1:0];
        tdwf_pkg::REG_ABORT_COUNTS:   cfg.abort_counts   <= cfg_data[tdwf_pkg::TILE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  tdwf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (load_out),
    .cfg  (cfg),
    .item (in_q),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule

### rtl/tdwf_steer.sv
// Proportional wall-follow steering and wheel speed clamp.
`timescale 1ns / 1ps

module tdwf_steer (
  input  tdwf_pkg::cfg_t                               cfg,
  input  tdwf_pkg::in_item_t                           item,
  output logic signed [tdwf_pkg::OUT_SPEED_BITS-1:0]   left_speed,
  output logic signed [tdwf_pkg::OUT_SPEED_BITS-1:0]   right_speed
);

  localparam int VW = tdwf_pkg::VAL_BITS;
  localparam int DW = tdwf_pkg::DIFF_BITS;
  localparam int SW = tdwf_pkg::STEER_BITS;
  localparam int PW = tdwf_pkg::SPD_BITS;
  localparam int OW = tdwf_pkg::OUT_SPEED_BITS;
  localparam logic signed [SW-1:0] GAIN_DIR_S  = SW'(tdwf_pkg::GAIN_DIR);
  localparam logic signed [SW-1:0] GAIN_DIST_S = SW'(tdwf_pkg::GAIN_DIST);

  logic [VW-1:0] rf, rb, lf, lb, th, tgt;
  logic signed [DW-1:0] d_r, d_l, e_r, e_l;
  logic signed [SW-1:0] p_r, p_l, s1_r, s1_l, t_r, t_l, v_r, v_l, steer_r, steer_l;
  logic signed [SW-1:0] steer;
  logic right_wall, left_wall;
  logic signed [PW-1:0] ms, ls_raw, rs_raw, ls_c, rs_c;

  assign rf  = VW'(item.right_front);
  assign rb  = VW'(item.right_back);
  assign lf  = VW'(item.left_front);
  assign lb  = VW'(item.left_back);
  assign th  = VW'(cfg.side_threshold);
  assign tgt = VW'(cfg.wall_target);

  assign d_r = $signed({1'b0, rf}) - $signed({1'b0, rb});
  assign d_l = $signed({1'b0, lb}) - $signed({1'b0, lf});
  assign e_r = $signed({1'b0, tgt}) - $signed({1'b0, rf});
  assign e_l = $signed({1'b0, tgt}) - $signed({1'b0, lf});

  assign p_r  = SW'(d_r) * GAIN_DIR_S;
  assign p_l  = SW'(d_l) * GAIN_DIR_S;
  assign s1_r = tdwf_pkg::div256_trunc(p_r);
  assign s1_l = tdwf_pkg::div256_trunc(p_l);
  assign t_r  = SW'(e_r) * GAIN_DIST_S;
  assign t_l  = SW'(e_l) * GAIN_DIST_S;
  assign v_r  = (s1_r <<< 8) - t_r;
  assign v_l  = (s1_l <<< 8) + t_l;
  assign steer_r = tdwf_pkg::div256_trunc(v_r);
  assign steer_l = tdwf_pkg::div256_trunc(v_l);

  assign right_wall = (rf > th) && (rb > th);
  assign left_wall  = (lf > th) && (lb > th);

  always_comb begin
    if (right_wall) begin
      steer = steer_r;
    end else if (left_wall) begin
      steer = steer_l;
    end else begin
      steer = '0;
    end
  end

  assign ms     = $signed({{(PW - tdwf_pkg::SPEED_BITS){1'b0}}, cfg.max_speed});
  assign ls_raw = ms - PW'(steer);
  assign rs_raw = ms + PW'(steer);

  always_comb begin
    ls_c = ls_raw;
    if (ls_raw > ms) ls_c = ms;
    if (ls_raw < -ms) ls_c = -ms;
    rs_c = rs_raw;
    if (rs_raw > ms) rs_c = ms;
    if (rs_raw < -ms) rs_c = -ms;
  end

  assign left_speed  = ls_c[OW-1:0];
  assign right_speed = rs_c[OW-1:0];

endmodule

### rtl/tdwf_ctrl.sv
// Run state, stop rules and result assembly for one control tick.
`timescale 1ns / 1ps

module tdwf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  tdwf_pkg::cfg_t       cfg,
  input  tdwf_pkg::in_item_t   item,
  output tdwf_pkg::out_item_t  res
);

  localparam int VW = tdwf_pkg::VAL_BITS;
  localparam int DW = tdwf_pkg::DIFF_BITS;
  localparam int CW = tdwf_pkg::COUNT_BITS;
  localparam int QW = tdwf_pkg::POS_BITS;
  localparam int OW = tdwf_pkg::OUT_SPEED_BITS;
  localparam logic signed [DW-1:0] FB_MARGIN = DW'(tdwf_pkg::FRONT_BACK_MARGIN);

  logic [1:0]           phase, phase_next;
  logic [2:0]           target_kind, target_kind_next;
  logic signed [CW-1:0] start_position, start_position_next;
  logic                 middle_reported, middle_reported_next;

  logic [VW-1:0] tf, tb, fs;
  logic signed [DW-1:0] fb_diff;
  logic signed [QW-1:0] lc, rc, lc_adj, rc_adj, lh, rh, pos, st;
  logic signed [QW-1:0] lim_tile, lim_half, lim_abort;
  logic moved, past_tile, past_half, past_abort;
  logic signed [OW-1:0] left_speed, right_speed;

  tdwf_steer u_steer (
    .cfg         (cfg),
    .item        (item),
    .left_speed  (left_speed),
    .right_speed (right_speed)
  );

  assign tf = VW'(item.top_front);
  assign tb = VW'(item.top_back);
  assign fs = VW'(cfg.front_stop);
  assign fb_diff = $signed({1'b0, tf}) - $signed({1'b0, tb});

  // Halve each count toward zero, then sum
  assign lc     = QW'(item.left_count);
  assign rc     = QW'(item.right_count);
  assign lc_adj = lc + QW'(lc[QW-1]);
  assign rc_adj = rc + QW'(rc[QW-1]);
  assign lh     = lc_adj >>> 1;
  assign rh     = rc_adj >>> 1;
  assign pos    = lh + rh;
  assign st     = QW'(start_position);

  assign lim_tile  = st + QW'(cfg.tile_counts);
  assign lim_half  = st + QW'(cfg.tile_counts[tdwf_pkg::TILE_BITS-1:1]);
  assign lim_abort = st + QW'(cfg.abort_counts);

  assign moved      = pos > st;
  assign past_tile  = pos > lim_tile;
  assign past_half  = pos > lim_half;
  assign past_abort = pos > lim_abort;

  always_comb begin
    phase_next           = phase;
    target_kind_next     = target_kind;
    start_position_next  = start_position;
    middle_reported_next = middle_reported;
    res                  = '0;
    unique case (phase) inside
      tdwf_pkg::PH_IDLE: begin
        start_position_next = pos[CW-1:0];
        phase_next          = tdwf_pkg::PH_DRIVE;
        res.status          = tdwf_pkg::ST_DRIVING;
        if (fb_diff > FB_MARGIN) begin
          if (tf > fs) begin
            phase_next       = tdwf_pkg::PH_DONE;
            target_kind_next = tdwf_pkg::KIND_NONE;
          end else if (tf > VW'(tdwf_pkg::KIND1_FRONT_TH)) begin
            target_kind_next = tdwf_pkg::KIND_FRONT;
          end else if (tf > VW'(tdwf_pkg::KIND2_FRONT_TH)) begin
            target_kind_next = tdwf_pkg::KIND_FRONT2;
          end else begin
            target_kind_next = tdwf_pkg::KIND_DIST;
          end
        end else begin
          if (tb > VW'(tdwf_pkg::KIND4_BACK_TH)) begin
            target_kind_next = tdwf_pkg::KIND_BACK4;
          end else if (tb > VW'(tdwf_pkg::KIND5_BACK_TH)) begin
            target_kind_next = tdwf_pkg::KIND_BACK5;
          end else begin
            target_kind_next = tdwf_pkg::KIND_DIST6;
          end
        end
      end
      tdwf_pkg::PH_DRIVE: begin
        if (tf > fs) phase_next = tdwf_pkg::PH_DONE;
        case (target_kind) inside
          tdwf_pkg::KIND_FRONT: begin
            if (tf > fs && moved) phase_next = tdwf_pkg::PH_DONE;
          end
          tdwf_pkg::KIND_FRONT2: begin
            if (tf > VW'(tdwf_pkg::KIND2_FRONT_STOP) && moved) phase_next = tdwf_pkg::PH_DONE;
          end
          tdwf_pkg::KIND_DIST, tdwf_pkg::KIND_DIST6: begin
            if (past_tile) phase_next = tdwf_pkg::PH_DONE;
          end
          tdwf_pkg::KIND_BACK4: begin
            if (tb < VW'(tdwf_pkg::KIND4_BACK_STOP) && moved) phase_next = tdwf_pkg::PH_DONE;
          end
          tdwf_pkg::KIND_BACK5: begin
            if (tb < VW'(tdwf_pkg::KIND5_BACK_STOP) && moved) phase_next = tdwf_pkg::PH_DONE;
          end
          default: ;
        endcase
        if (past_abort) phase_next = tdwf_pkg::PH_DONE;
        res.speeds_valid = 1'b1;
        res.left_speed   = left_speed;
        res.right_speed  = right_speed;
        if (past_half) begin
          if (!middle_reported) begin
            res.status           = tdwf_pkg::ST_MIDDLE;
            middle_reported_next = 1'b1;
          end else begin
            res.status = tdwf_pkg::ST_DRIVING;
          end
        end else begin
          res.status = tdwf_pkg::ST_BEFORE;
        end
      end
      tdwf_pkg::PH_DONE, tdwf_pkg::PH_SPARE: begin
        phase_next           = tdwf_pkg::PH_IDLE;
        middle_reported_next = 1'b0;
        res.status           = tdwf_pkg::ST_DONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tdwf_pkg::PH_IDLE;
      target_kind     <= tdwf_pkg::KIND_NONE;
      start_position  <= '0;
      middle_reported <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      target_kind     <= target_kind_next;
      start_position  <= start_position_next;
      middle_reported <= middle_reported_next;
    end
  end

`ifndef SYNTHESIS
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    step && (phase == tdwf_pkg::PH_DONE) |=> (phase == tdwf_pkg::PH_IDLE) && !middle_reported)
    else $error("done tick did not return to idle");

  a_start_kind: assert property (@(posedge clk) disable iff (rst)
    step && (phase == tdwf_pkg::PH_IDLE) |=>
      ((phase == tdwf_pkg::PH_DRIVE) && (target_kind != tdwf_pkg::KIND_NONE)
        && (target_kind != tdwf_pkg::KIND_SPARE))
      || ((phase == tdwf_pkg::PH_DONE) && (target_kind == tdwf_pkg::KIND_NONE)))
    else $error("bad stop rule chosen at start");

  a_middle_once: assert property (@(posedge clk) disable iff (rst)
    step && middle_reported |-> res.status != tdwf_pkg::ST_MIDDLE)
    else $error("middle reported twice in one run");

  a_speed_clamp: assert property (@(posedge clk) disable iff (rst)
    res.speeds_valid |->
      ($signed({1'b0, cfg.max_speed}) >= res.left_speed)
      && (-$signed({1'b0, cfg.max_speed}) <= res.left_speed)
      && ($signed({1'b0, cfg.max_speed}) >= res.right_speed)
      && (-$signed({1'b0, cfg.max_speed}) <= res.right_speed))
    else $error("wheel speed outside limit");
`endif

endmodule
